### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hw/rtl/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// Types, byte class codes and helpers for the syllable segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package iss_pkg;

  localparam logic [7:0] HALANT   = 8'hE8;
  localparam logic [7:0] NUKHTA   = 8'hE9;
  localparam logic [7:0] SWITCH   = 8'hEF;
  localparam logic [7:0] CONS_LO  = 8'hB3;
  localparam logic [7:0] CONS_HI  = 8'hD8;
  localparam logic [7:0] MATRA_LO = 8'hDA;
  localparam logic [7:0] MATRA_HI = 8'hE7;

  // results one item can release
  localparam int SLOTS  = 3;
  // result queue
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SWITCH,
    PH_CONS,
    PH_CONS_H,
    PH_MATRA,
    PH_MATRA_H
  } phase_t;

  typedef enum logic [2:0] {
    ACT_START,        // no open syllable, new byte starts one
    ACT_CLOSE_START,  // close open syllable, new byte starts afresh
    ACT_CUT_START,    // same, closed at the length limit
    ACT_ADD_CLOSE,    // new byte joins and closes the syllable
    ACT_SHIFT,        // held byte joins, new byte becomes the held byte
    ACT_APPEND,       // halant after matra waits as second held byte
    ACT_SPLIT         // matra halant consonant: halant stands alone
  } act_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       syllable_end;
    logic       conjunct;
    logic       length_cut;
    logic       stream_done;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic [1:0]           cnt;
    res_t [SLOTS-1:0]     slot;
  } push_t;

  function automatic res_t make_res(logic [7:0] b, logic e, logic c, logic k);
    res_t r;
    r.out_byte     = b;
    r.syllable_end = e;
    r.conjunct     = e & c;
    r.length_cut   = e & k;
    r.stream_done  = 1'b0;
    r.run_last     = 1'b0;
    return r;
  endfunction

  // bytes held while the given phase is open
  function automatic logic [1:0] held_cnt(phase_t p);
    logic [1:0] n;
    unique case (p)
      PH_IDLE:    n = 2'd0;
      PH_MATRA_H: n = 2'd2;
      default:    n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/iss_if.sv
// ----------------------------------------------------------------------------
// iss_if
// Valid/ready channels for input bytes and result bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface iss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, in_byte, end_of_stream, input ready);
  modport sink   (input valid, in_byte, end_of_stream, output ready);
endinterface

interface iss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       syllable_end;
  logic       conjunct;
  logic       length_cut;
  logic       stream_done;
  logic       run_last;

  modport source (output valid, out_byte, syllable_end, conjunct, length_cut,
                  stream_done, run_last, input ready);
  modport sink   (input valid, out_byte, syllable_end, conjunct, length_cut,
                  stream_done, run_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/iscii_syllable_segmenter_unit.sv
// ----------------------------------------------------------------------------
// iscii_syllable_segmenter_unit
// Splits an ISCII byte stream into syllables and marks syllable ends.
// ----------------------------------------------------------------------------
// in_ch carries one byte per item with its end-of-stream flag; out_ch carries
// every byte back in order with syllable_end, conjunct, length_cut,
// stream_done and run_last (last result caused by one input item).
// An accepted byte waits in the input register until the queue has room,
// then the parser releases 0..3 results into an 8-entry result queue, from
// which each result is offered in order. Bytes of an open cluster are held
// back (up to two) until a following byte or the end of stream decides
// their syllable.
// Throughput is one byte per cycle while the queue has room: the parser
// decides each byte in one pass and every byte leaves exactly once. Input is
// taken while the queue has room for a three-result burst; when out_ch stalls
// the queue fills and in_ch.ready drops with a byte waiting for room.
// Synchronous reset empties the queue and returns the parser to idle with
// no open syllable; the end of each stream returns the parser to idle too.
// ----------------------------------------------------------------------------
`default_nettype none

module iscii_syllable_segmenter_unit #(
  parameter int MAX_SYLLABLE_BYTES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  iss_in_if.sink    in_ch,
  iss_out_if.source out_ch
);
  import iss_pkg::*;

  logic       item_v_r;
  logic [7:0] item_byte_r;
  logic       item_eos_r;
  logic       room;
  logic       step;
  push_t      push;

  assign step        = item_v_r && room;
  assign in_ch.ready = !item_v_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_byte_r <= in_ch.in_byte;
      item_eos_r  <= in_ch.end_of_stream;
    end
  end

  iss_parse #(
    .MAX_SYLLABLE_BYTES(MAX_SYLLABLE_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (item_byte_r),
    .eos_i  (item_eos_r),
    .push_o (push)
  );

  iss_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .room_o (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### hw/rtl/iss_parse.sv
// ----------------------------------------------------------------------------
// iss_parse
// Syllable state and per-byte decision; releases up to three results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module iss_parse #(
  parameter int MAX_SYLLABLE_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  input  logic          eos_i,
  output iss_pkg::push_t push_o
);
  import iss_pkg::*;

  localparam int LenW = $clog2(MAX_SYLLABLE_BYTES + 1);

  phase_t          phase_r, phase_nxt, par_phase;
  logic [7:0]      h0_r, h1_r, par_h0, par_h1;
  logic [LenW-1:0] len_r, len_nxt, par_len;
  logic            conj_r, conj_nxt, par_conj;

  act_t            act;
  logic            x_cons, x_mat, x_hal, x_nuk, x_sw, x_lone, full, cut;
  logic [1:0]      n;
  res_t [SLOTS-1:0] slots;

  assign x_cons = (byte_i >= CONS_LO) && (byte_i <= CONS_HI);
  assign x_mat  = (byte_i >= MATRA_LO) && (byte_i <= MATRA_HI);
  assign x_hal  = (byte_i == HALANT);
  assign x_nuk  = (byte_i == NUKHTA);
  assign x_sw   = (byte_i == SWITCH);
  assign x_lone = !x_cons && !x_sw;
  assign full   = (len_r >= LenW'(MAX_SYLLABLE_BYTES));
  assign cut    = (act == ACT_CUT_START);

  // decision for the new byte
  always_comb begin
    act = ACT_START;
    unique case (phase_r)
      PH_IDLE:   act = ACT_START;
      PH_SWITCH: act = ACT_ADD_CLOSE;
      PH_CONS: begin
        if (x_hal || x_mat) act = full ? ACT_CUT_START : ACT_SHIFT;
        else if (x_nuk)     act = full ? ACT_CUT_START : ACT_ADD_CLOSE;
        else                act = ACT_CLOSE_START;
      end
      PH_CONS_H: begin
        if (x_cons)     act = full ? ACT_CUT_START : ACT_SHIFT;
        else if (x_nuk) act = full ? ACT_CUT_START : ACT_ADD_CLOSE;
        else            act = ACT_CLOSE_START;
      end
      PH_MATRA: begin
        if (x_hal)      act = full ? ACT_CUT_START : ACT_APPEND;
        else if (x_nuk) act = full ? ACT_CUT_START : ACT_ADD_CLOSE;
        else            act = ACT_CLOSE_START;
      end
      PH_MATRA_H: begin
        if (x_cons)     act = ACT_SPLIT;
        else if (x_nuk) act = full ? ACT_CUT_START : ACT_ADD_CLOSE;
        else            act = ACT_CLOSE_START;
      end
      default: act = ACT_START;
    endcase
  end

  // next state before the end-of-stream flush
  always_comb begin
    par_phase = phase_r;
    par_h0    = h0_r;
    par_h1    = h1_r;
    par_len   = len_r;
    par_conj  = conj_r;
    unique case (act)
      ACT_START, ACT_CLOSE_START, ACT_CUT_START, ACT_SPLIT: begin
        par_h0   = byte_i;
        par_conj = 1'b0;
        if (x_cons) begin
          par_phase = PH_CONS;
          par_len   = LenW'(1);
        end else if (x_sw) begin
          par_phase = PH_SWITCH;
          par_len   = LenW'(1);
        end else begin
          par_phase = PH_IDLE;
          par_len   = '0;
        end
      end
      ACT_ADD_CLOSE: begin
        par_phase = PH_IDLE;
        par_len   = '0;
        par_conj  = 1'b0;
      end
      ACT_SHIFT: begin
        par_h0   = byte_i;
        par_len  = len_r + LenW'(1);
        par_conj = conj_r | (phase_r == PH_CONS_H);
        if (phase_r == PH_CONS_H) par_phase = PH_CONS;
        else if (x_hal)           par_phase = PH_CONS_H;
        else                      par_phase = PH_MATRA;
      end
      ACT_APPEND: begin
        par_h1    = byte_i;
        par_len   = len_r + LenW'(1);
        par_phase = PH_MATRA_H;
      end
      default: par_phase = phase_r;
    endcase
  end

  // end of stream puts everything back to reset
  assign phase_nxt = eos_i ? PH_IDLE : par_phase;
  assign len_nxt   = eos_i ? '0 : par_len;
  assign conj_nxt  = eos_i ? 1'b0 : par_conj;

  // released results
  always_comb begin
    n     = 2'd0;
    slots = '0;
    unique case (act)
      ACT_START: begin
        if (x_lone) begin
          slots[n] = make_res(byte_i, 1'b1, 1'b0, 1'b0);
          n = n + 2'd1;
        end
      end
      ACT_CLOSE_START, ACT_CUT_START: begin
        if (phase_r == PH_MATRA_H) begin
          slots[n] = make_res(h0_r, 1'b0, 1'b0, 1'b0);
          n = n + 2'd1;
          slots[n] = make_res(h1_r, 1'b1, conj_r, cut);
          n = n + 2'd1;
        end else begin
          slots[n] = make_res(h0_r, 1'b1, conj_r, cut);
          n = n + 2'd1;
        end
        if (x_lone) begin
          slots[n] = make_res(byte_i, 1'b1, 1'b0, 1'b0);
          n = n + 2'd1;
        end
      end
      ACT_ADD_CLOSE: begin
        slots[n] = make_res(h0_r, 1'b0, 1'b0, 1'b0);
        n = n + 2'd1;
        if (phase_r == PH_MATRA_H) begin
          slots[n] = make_res(h1_r, 1'b0, 1'b0, 1'b0);
          n = n + 2'd1;
        end
        slots[n] = make_res(byte_i, 1'b1, conj_r, 1'b0);
        n = n + 2'd1;
      end
      ACT_SHIFT: begin
        slots[n] = make_res(h0_r, 1'b0, 1'b0, 1'b0);
        n = n + 2'd1;
      end
      ACT_SPLIT: begin
        // cluster closes before the halant, halant is a syllable alone
        slots[n] = make_res(h0_r, 1'b1, conj_r, 1'b0);
        n = n + 2'd1;
        slots[n] = make_res(h1_r, 1'b1, 1'b0, 1'b0);
        n = n + 2'd1;
      end
      default: n = 2'd0;
    endcase

    // flush held bytes at end of stream
    if (eos_i) begin
      if (held_cnt(par_phase) == 2'd2) begin
        slots[n] = make_res(par_h0, 1'b0, 1'b0, 1'b0);
        n = n + 2'd1;
        slots[n] = make_res(par_h1, 1'b1, par_conj, 1'b0);
        n = n + 2'd1;
      end else if (held_cnt(par_phase) == 2'd1) begin
        slots[n] = make_res(par_h0, 1'b1, par_conj, 1'b0);
        n = n + 2'd1;
      end
    end

    if (n != 2'd0) begin
      slots[n - 2'd1].run_last    = 1'b1;
      slots[n - 2'd1].stream_done = eos_i;
    end
  end

  assign push_o.cnt  = step_i ? n : 2'd0;
  assign push_o.slot = slots;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      len_r   <= '0;
      conj_r  <= 1'b0;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      conj_r  <= conj_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i) begin
      h0_r <= par_h0;
      h1_r <= par_h1;
    end
  end

  `ASSERT_NEVER(a_len_bound, len_r > LenW'(MAX_SYLLABLE_BYTES), "syllable length over limit")
  `ASSERT_CLK(a_mh_halant, phase_r == PH_MATRA_H |-> h1_r == HALANT, "second held byte not halant")
  `ASSERT_CLK(a_idle_clear, phase_r == PH_IDLE |-> (len_r == '0 && !conj_r), "idle with open state")

endmodule

`default_nettype wire

### hw/rtl/iss_queue.sv
// ----------------------------------------------------------------------------
// iss_queue
// Result queue: takes up to three results a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module iss_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  iss_pkg::push_t   push_i,
  output logic             room_o,
  iss_out_if.source        out_ch
);
  import iss_pkg::*;

  res_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r;
  logic           pop;
  res_t           head;

  assign pop    = out_ch.valid && out_ch.ready;
  // room for a full burst from one item
  assign room_o = (cnt_r <= QCW'(QDEPTH - SLOTS));
  assign head   = mem_r[rp_r];

  assign out_ch.valid        = (cnt_r != '0);
  assign out_ch.out_byte     = head.out_byte;
  assign out_ch.syllable_end = head.syllable_end;
  assign out_ch.conjunct     = head.conjunct;
  assign out_ch.length_cut   = head.length_cut;
  assign out_ch.stream_done  = head.stream_done;
  assign out_ch.run_last     = head.run_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + QAW'(push_i.cnt);
      rp_r  <= rp_r + QAW'(pop);
      cnt_r <= cnt_r + QCW'(push_i.cnt) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SLOTS; k++) begin
      if (k < int'(push_i.cnt)) begin
        mem_r[wp_r + QAW'(k)] <= push_i.slot[k];
      end
    end
  end

  `ASSERT_NEVER(a_push_room, push_i.cnt != 2'd0 && !room_o, "push without room")
  `ASSERT_NEVER(a_q_over, cnt_r > QCW'(QDEPTH), "result queue overflow")

endmodule

`default_nettype wire

### test/iscii_syllable_segmenter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iscii_syllable_segmenter_unit_test
// Self-checking bench: feeds ISCII byte streams, predicts every released byte
// with its syllable flags and compares each result as it leaves the block.
// ----------------------------------------------------------------------------

module iscii_syllable_segmenter_unit_test;
  import iss_pkg::*;

  localparam int MAX_SYL        = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 12;

  typedef logic [7:0] byte_seq_t[$];

  logic clk;
  logic rst_n;

  iss_in_if  in_if();
  iss_out_if out_if();

  iscii_syllable_segmenter_unit #(
    .MAX_SYLLABLE_BYTES(MAX_SYL)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // segmenter state kept by the bench
  logic [7:0]  held_q [2];
  int unsigned held_n;
  phase_t      seg_phase;
  int unsigned syl_len;
  logic        conj_on;
  res_t        burst_q[$];

  res_t        expected_bytes_q[$];
  logic [7:0]  syl_bytes_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int items_sent;
  int results_seen;
  int syllables_seen;
  int conjuncts_seen;
  int cuts_seen;
  int streams_seen;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic cons_byte(logic [7:0] x);
    return x >= CONS_LO && x <= CONS_HI;
  endfunction

  function automatic logic vowel_sign(logic [7:0] x);
    return x >= MATRA_LO && x <= MATRA_HI;
  endfunction

  function automatic void push_res(logic [7:0] b, logic e, logic k);
    res_t r;
    r.out_byte     = b;
    r.syllable_end = e;
    r.conjunct     = e & conj_on;
    r.length_cut   = e & k;
    r.stream_done  = 1'b0;
    r.run_last     = 1'b0;
    burst_q.push_back(r);
  endfunction

  function automatic void drop_syllable();
    held_n    = 0;
    seg_phase = PH_IDLE;
    syl_len   = 0;
    conj_on   = 1'b0;
  endfunction

  function automatic void close_open(logic k);
    int unsigned n;
    n = held_n;
    for (int unsigned i = 0; i < n; i++) push_res(held_q[i], i + 1 == n, k);
    drop_syllable();
  endfunction

  function automatic void open_with(logic [7:0] x);
    if (cons_byte(x) || x == SWITCH) begin
      held_q[0] = x;
      held_n    = 1;
      syl_len   = 1;
      seg_phase = cons_byte(x) ? PH_CONS : PH_SWITCH;
    end else begin
      push_res(x, 1'b1, 1'b0);
    end
  endfunction

  function automatic void join_and_close(logic [7:0] x);
    for (int unsigned i = 0; i < held_n; i++) push_res(held_q[i], 1'b0, 1'b0);
    push_res(x, 1'b1, 1'b0);
    drop_syllable();
  endfunction

  function automatic void cut_and_restart(logic [7:0] x);
    close_open(1'b1);
    open_with(x);
  endfunction

  function automatic void close_and_restart(logic [7:0] x);
    close_open(1'b0);
    open_with(x);
  endfunction

  function automatic void take_nukhta(logic [7:0] x);
    if (syl_len >= MAX_SYL) cut_and_restart(x);
    else join_and_close(x);
  endfunction

  // held byte goes out, new byte becomes the held one
  function automatic void shift_held(logic [7:0] x, phase_t p);
    push_res(held_q[0], 1'b0, 1'b0);
    held_q[0] = x;
    held_n    = 1;
    syl_len++;
    seg_phase = p;
  endfunction

  function automatic void segment_byte(logic [7:0] x, logic last);
    logic       full;
    logic [7:0] h;
    res_t       r;
    burst_q.delete();
    full = syl_len >= MAX_SYL;
    case (seg_phase)
      PH_SWITCH: join_and_close(x);
      PH_CONS: begin
        if (x == HALANT || vowel_sign(x)) begin
          if (full) cut_and_restart(x);
          else shift_held(x, x == HALANT ? PH_CONS_H : PH_MATRA);
        end else if (x == NUKHTA) begin
          take_nukhta(x);
        end else begin
          close_and_restart(x);
        end
      end
      PH_CONS_H: begin
        if (cons_byte(x)) begin
          if (full) begin
            cut_and_restart(x);
          end else begin
            shift_held(x, PH_CONS);
            conj_on = 1'b1;
          end
        end else if (x == NUKHTA) begin
          take_nukhta(x);
        end else begin
          close_and_restart(x);
        end
      end
      PH_MATRA: begin
        if (x == HALANT) begin
          if (full) begin
            cut_and_restart(x);
          end else begin
            held_q[1] = x;
            held_n    = 2;
            syl_len++;
            seg_phase = PH_MATRA_H;
          end
        end else if (x == NUKHTA) begin
          take_nukhta(x);
        end else begin
          close_and_restart(x);
        end
      end
      PH_MATRA_H: begin
        if (cons_byte(x)) begin
          // the halant between matra and consonant stands alone
          h      = held_q[1];
          held_n = 1;
          close_open(1'b0);
          open_with(h);
          open_with(x);
        end else if (x == NUKHTA) begin
          take_nukhta(x);
        end else begin
          close_and_restart(x);
        end
      end
      default: begin
        drop_syllable();
        open_with(x);
      end
    endcase
    if (last) begin
      if (held_n > 0) close_open(1'b0);
      drop_syllable();
    end
    for (int i = 0; i < burst_q.size(); i++) begin
      r = burst_q[i];
      if (i == burst_q.size() - 1) begin
        r.run_last    = 1'b1;
        r.stream_done = last;
      end
      expected_bytes_q.push_back(r);
    end
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_if.valid && out_if.ready) begin
        got.out_byte     = out_if.out_byte;
        got.syllable_end = out_if.syllable_end;
        got.conjunct     = out_if.conjunct;
        got.length_cut   = out_if.length_cut;
        got.stream_done  = out_if.stream_done;
        got.run_last     = out_if.run_last;
        results_seen++;
        if (got.syllable_end) syllables_seen++;
        if (got.syllable_end && got.conjunct) conjuncts_seen++;
        if (got.syllable_end && got.length_cut) cuts_seen++;
        if (got.stream_done) streams_seen++;
        if (expected_bytes_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = expected_bytes_q.pop_front();
          compare_field("out_byte", want.out_byte, got.out_byte);
          compare_field("syllable_end", want.syllable_end, got.syllable_end);
          compare_field("conjunct", want.conjunct, got.conjunct);
          compare_field("length_cut", want.length_cut, got.length_cut);
          compare_field("stream_done", want.stream_done, got.stream_done);
          compare_field("run_last", want.run_last, got.run_last);
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, expected_bytes_q.size());
        $display("iscii_syllable_segmenter_unit regression: fail");
        $finish;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // enters and leaves at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid         = 1'b1;
    in_if.in_byte       = b;
    in_if.end_of_stream = last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    segment_byte(b, last);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (expected_bytes_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // whole stream, end of stream on the last byte
  task automatic send_stream(input byte_seq_t seq);
    for (int i = 0; i < seq.size(); i++) send_byte(seq[i], i == seq.size() - 1);
    drain();
  endtask

  function automatic logic [7:0] rand_cons();
    return 8'($urandom_range(CONS_HI, CONS_LO));
  endfunction

  function automatic logic [7:0] rand_matra();
    return 8'($urandom_range(MATRA_HI, MATRA_LO));
  endfunction

  function automatic void build_syllable();
    int kind;
    int pairs;
    kind = $urandom_range(99);
    if (kind < 45) begin
      syl_bytes_q.push_back(rand_cons());
      // now and then a chain long enough to hit the length limit
      pairs = ($urandom_range(14) == 0) ? $urandom_range(10, 6) : $urandom_range(3);
      repeat (pairs) begin
        syl_bytes_q.push_back(HALANT);
        syl_bytes_q.push_back(rand_cons());
      end
      if ($urandom_range(1)) syl_bytes_q.push_back(rand_matra());
      if ($urandom_range(9) < 3) syl_bytes_q.push_back(HALANT);
      if ($urandom_range(3) == 0) syl_bytes_q.push_back(NUKHTA);
    end else if (kind < 55) begin
      syl_bytes_q.push_back(SWITCH);
      syl_bytes_q.push_back(8'($urandom_range(255)));
    end else if (kind < 65) begin
      syl_bytes_q.push_back(8'($urandom_range(8'hB2, 8'hA4)));
    end else if (kind < 72) begin
      syl_bytes_q.push_back(rand_cons());
      syl_bytes_q.push_back(rand_matra());
      syl_bytes_q.push_back(HALANT);
      syl_bytes_q.push_back(rand_cons());
    end else if (kind < 80) begin
      case ($urandom_range(2))
        0:       syl_bytes_q.push_back(rand_matra());
        1:       syl_bytes_q.push_back(HALANT);
        default: syl_bytes_q.push_back(NUKHTA);
      endcase
    end else begin
      syl_bytes_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic run_random(input int n, input int idle_pct, input int stall_pct);
    int         sent;
    logic       last;
    logic [7:0] b;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    last = 1'b0;
    while (sent < n) begin
      build_syllable();
      while (syl_bytes_q.size() != 0) begin
        b    = syl_bytes_q.pop_front();
        last = (syl_bytes_q.size() == 0 && $urandom_range(11) == 0) ||
               $urandom_range(59) == 0;
        send_byte(b, last);
        sent++;
      end
    end
    if (!last) send_byte(8'($urandom_range(255)), 1'b1);
    drain();
  endtask

  task automatic test_lone_bytes();
    send_stream('{8'h00, 8'hFF, 8'hA4, MATRA_LO, HALANT, NUKHTA, SWITCH, 8'h41, SWITCH});
  endtask

  task automatic test_clusters();
    // conjunct with matra and nukhta, then matra halant consonant, then
    // a halant closing the stream after a consonant
    send_stream('{CONS_LO, HALANT, CONS_HI, MATRA_HI, NUKHTA,
                  8'hC0, MATRA_LO, HALANT, 8'hC5, HALANT});
  endtask

  task automatic test_length_limit();
    byte_seq_t seq;
    seq.push_back(CONS_LO);
    repeat (MAX_SYL / 2 - 1) begin
      seq.push_back(HALANT);
      seq.push_back(8'hC0);
    end
    seq.push_back(HALANT);
    // syllable is full here: the consonant must start afresh
    seq.push_back(8'hC1);
    seq.push_back(NUKHTA);
    send_stream(seq);
  endtask

  task automatic test_random_traffic();
    run_random(75, 0, 0);
    run_random(75, 67, 0);
    run_random(75, 0, 67);
    run_random(75, 19, 19);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.in_byte       = 8'h00;
    in_if.end_of_stream = 1'b0;
    out_if.ready        = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    mismatches          = 0;
    items_sent          = 0;
    results_seen        = 0;
    syllables_seen      = 0;
    conjuncts_seen      = 0;
    cuts_seen           = 0;
    streams_seen        = 0;
    quiet_cycles        = 0;
    held_q[0]           = 8'h00;
    held_q[1]           = 8'h00;
    drop_syllable();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_lone_bytes();
    test_clusters();
    test_length_limit();
    test_random_traffic();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_bytes_q.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, expected_bytes_q.size());
      mismatches++;
    end
    $display("sent %0d bytes, checked %0d results in %0d streams", items_sent,
             results_seen, streams_seen);
    $display("closed %0d syllables: %0d conjunct, %0d cut at length limit",
             syllables_seen, conjuncts_seen, cuts_seen);
    if (mismatches == 0) begin
      $display("iscii_syllable_segmenter_unit regression: pass");
    end else begin
      $display("iscii_syllable_segmenter_unit regression: fail");
    end
    $finish;
  end

endmodule
